@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen out of reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/cwt_pkg.sv @@
package cwt_pkg;

	localparam int CHAR_W    = 8;
	localparam int LEN_W     = 10;
	localparam int KIND_W    = 2;
	localparam int ITEMS_MAX = 4;
	localparam int CNT_W     = 3;
	localparam int IDX_W     = 2;

	localparam logic [LEN_W-1:0] LEN_RESET = 10'd1023;

	localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
	localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
	localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

	localparam logic [KIND_W-1:0] KIND_WORD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LIT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SYM  = 2'd2;

	typedef enum logic [7:0] {
		MODE_IDLE  = 8'b0000_0001,
		MODE_SLASH = 8'b0000_0010,
		MODE_LINE  = 8'b0000_0100,
		MODE_BLOCK = 8'b0000_1000,
		MODE_STAR  = 8'b0001_0000,
		MODE_WORD  = 8'b0010_0000,
		MODE_LIT   = 8'b0100_0000,
		MODE_ESC   = 8'b1000_0000
	} mode_t;

	typedef struct packed {
		logic [CHAR_W-1:0] token_char;
		logic              token_end;
		logic [KIND_W-1:0] token_kind;
		logic              comment_error;
	} res_t;

	typedef struct packed {
		res_t [ITEMS_MAX-1:0] items;
		logic [CNT_W-1:0]     n;
	} grp_t;

	function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic logic [CHAR_W-1:0] translate(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		unique case (c)
			8'h61: r = 8'h07;
			8'h62: r = 8'h08;
			8'h74: r = 8'h09;
			8'h6E: r = 8'h0A;
			8'h76: r = 8'h0B;
			8'h66: r = 8'h0C;
			8'h72: r = 8'h0D;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/cwt_if.sv @@
interface cwt_in_if;
	logic                          valid;
	logic                          ready;
	logic [cwt_pkg::CHAR_W-1:0]    character;
	logic                          end_of_input;

	modport source (output valid, output character, output end_of_input, input ready);
	modport sink (input valid, input character, input end_of_input, output ready);
endinterface

interface cwt_out_if;
	logic                          valid;
	logic                          ready;
	logic [cwt_pkg::CHAR_W-1:0]    token_char;
	logic                          token_end;
	logic [cwt_pkg::KIND_W-1:0]    token_kind;
	logic                          comment_error;

	modport source (output valid, output token_char, output token_end, output token_kind,
		output comment_error, input ready);
	modport sink (input valid, input token_char, input token_end, input token_kind,
		input comment_error, output ready);
endinterface

interface cwt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [cwt_pkg::LEN_W-1:0]     max_token_length;

	modport source (output valid, output max_token_length, input ready);
	modport sink (input valid, input max_token_length, output ready);
endinterface

@@ rtl/cwt_scan.sv @@
`include "assert_macros.svh"

module cwt_scan (
	input  logic                clk,
	input  logic                arst_n,
	cwt_in_if.sink              src,
	cwt_cfg_if.sink             cfg,
	input  logic                free,
	output cwt_pkg::grp_t       grp,
	output logic                grp_load
);

	logic                              valid_s1;
	logic [cwt_pkg::CHAR_W-1:0]        char_s1;
	logic                              eoi_s1;

	cwt_pkg::mode_t                    mode_q, mode_d;
	logic [cwt_pkg::LEN_W-1:0]         tlen_q, tlen_d;
	logic                              quote_q, quote_d;
	logic [cwt_pkg::LEN_W-1:0]         mtl_q;

	logic [cwt_pkg::LEN_W-1:0]         lim;
	logic [cwt_pkg::CHAR_W-1:0]        quote_ch;
	logic                              advance;

	logic                              run_idle;
	logic                              do_app;
	logic [cwt_pkg::CHAR_W-1:0]        app_ch;
	logic [cwt_pkg::KIND_W-1:0]        app_kind;
	logic [cwt_pkg::LEN_W-1:0]         app_base;
	logic [cwt_pkg::LEN_W-1:0]         app_len;

	assign cfg.ready = 1'b1;
	assign lim       = (mtl_q == '0) ? cwt_pkg::LEN_W'(1) : mtl_q;
	assign quote_ch  = quote_q ? cwt_pkg::CH_SQUOTE : cwt_pkg::CH_DQUOTE;
	assign advance   = valid_s1 && (free || grp.n == '0);
	assign grp_load  = valid_s1 && free && grp.n != '0;
	assign src.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mtl_q <= cwt_pkg::LEN_RESET;
		end else if (cfg.valid && cfg.ready) begin
			mtl_q <= cfg.max_token_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src.ready) begin
			valid_s1 <= src.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			char_s1 <= src.character;
			eoi_s1  <= src.end_of_input;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= cwt_pkg::MODE_IDLE;
			tlen_q  <= '0;
			quote_q <= 1'b0;
		end else if (advance) begin
			mode_q  <= mode_d;
			tlen_q  <= tlen_d;
			quote_q <= quote_d;
		end
	end

	always_comb begin
		grp      = '0;
		mode_d   = mode_q;
		tlen_d   = tlen_q;
		quote_d  = quote_q;
		run_idle = 1'b0;
		do_app   = 1'b0;
		app_ch   = '0;
		app_kind = cwt_pkg::KIND_WORD;
		app_base = tlen_q;
		app_len  = '0;
		if (eoi_s1) begin
			unique case (mode_q)
				cwt_pkg::MODE_WORD: begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
						cwt_pkg::KIND_WORD, 1'b0};
					grp.n = grp.n + 1'b1;
				end
				cwt_pkg::MODE_LIT, cwt_pkg::MODE_ESC: begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
						cwt_pkg::KIND_LIT, 1'b0};
					grp.n = grp.n + 1'b1;
				end
				cwt_pkg::MODE_SLASH: begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_SLASH, 1'b0,
						cwt_pkg::KIND_SYM, 1'b0};
					grp.n = grp.n + 1'b1;
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
						cwt_pkg::KIND_SYM, 1'b0};
					grp.n = grp.n + 1'b1;
				end
				cwt_pkg::MODE_BLOCK, cwt_pkg::MODE_STAR: begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b0,
						cwt_pkg::KIND_WORD, 1'b1};
					grp.n = grp.n + 1'b1;
				end
				default: begin
				end
			endcase
			mode_d  = cwt_pkg::MODE_IDLE;
			tlen_d  = '0;
			quote_d = 1'b0;
		end else begin
			unique case (mode_q)
				cwt_pkg::MODE_SLASH: begin
					if (char_s1 == cwt_pkg::CH_SLASH) begin
						mode_d = cwt_pkg::MODE_LINE;
					end else if (char_s1 == cwt_pkg::CH_STAR) begin
						mode_d = cwt_pkg::MODE_BLOCK;
					end else begin
						grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_SLASH, 1'b0,
							cwt_pkg::KIND_SYM, 1'b0};
						grp.n = grp.n + 1'b1;
						grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
							cwt_pkg::KIND_SYM, 1'b0};
						grp.n    = grp.n + 1'b1;
						mode_d   = cwt_pkg::MODE_IDLE;
						run_idle = 1'b1;
					end
				end
				cwt_pkg::MODE_LINE: begin
					if (char_s1 == cwt_pkg::CH_NL) begin
						mode_d = cwt_pkg::MODE_IDLE;
					end
				end
				cwt_pkg::MODE_BLOCK: begin
					if (char_s1 == cwt_pkg::CH_STAR) begin
						mode_d = cwt_pkg::MODE_STAR;
					end
				end
				cwt_pkg::MODE_STAR: begin
					if (char_s1 == cwt_pkg::CH_SLASH) begin
						mode_d = cwt_pkg::MODE_IDLE;
					end else if (char_s1 != cwt_pkg::CH_STAR) begin
						mode_d = cwt_pkg::MODE_BLOCK;
					end
				end
				cwt_pkg::MODE_WORD: begin
					if (cwt_pkg::is_alpha(char_s1) || cwt_pkg::is_digit(char_s1) ||
						char_s1 == cwt_pkg::CH_UNDER) begin
						do_app   = 1'b1;
						app_ch   = char_s1;
						app_kind = cwt_pkg::KIND_WORD;
					end else begin
						grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
							cwt_pkg::KIND_WORD, 1'b0};
						grp.n    = grp.n + 1'b1;
						mode_d   = cwt_pkg::MODE_IDLE;
						tlen_d   = '0;
						run_idle = 1'b1;
					end
				end
				cwt_pkg::MODE_LIT: begin
					if (char_s1 == quote_ch) begin
						grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
							cwt_pkg::KIND_LIT, 1'b0};
						grp.n  = grp.n + 1'b1;
						mode_d = cwt_pkg::MODE_IDLE;
						tlen_d = '0;
					end else if (char_s1 == cwt_pkg::CH_BSLASH) begin
						mode_d = cwt_pkg::MODE_ESC;
					end else begin
						do_app   = 1'b1;
						app_ch   = char_s1;
						app_kind = cwt_pkg::KIND_LIT;
					end
				end
				cwt_pkg::MODE_ESC: begin
					mode_d   = cwt_pkg::MODE_LIT;
					do_app   = 1'b1;
					app_ch   = cwt_pkg::translate(char_s1);
					app_kind = cwt_pkg::KIND_LIT;
				end
				default: begin
					mode_d   = cwt_pkg::MODE_IDLE;
					run_idle = 1'b1;
				end
			endcase

			if (run_idle) begin
				priority if (cwt_pkg::is_space(char_s1)) begin
					mode_d = cwt_pkg::MODE_IDLE;
				end else if (char_s1 == cwt_pkg::CH_SLASH) begin
					mode_d = cwt_pkg::MODE_SLASH;
				end else if (char_s1 == cwt_pkg::CH_DQUOTE || char_s1 == cwt_pkg::CH_SQUOTE) begin
					mode_d  = cwt_pkg::MODE_LIT;
					quote_d = (char_s1 == cwt_pkg::CH_SQUOTE);
					tlen_d  = '0;
				end else if (cwt_pkg::is_alpha(char_s1) || char_s1 == cwt_pkg::CH_UNDER ||
					char_s1 == cwt_pkg::CH_HASH) begin
					mode_d   = cwt_pkg::MODE_WORD;
					do_app   = 1'b1;
					app_ch   = char_s1;
					app_kind = cwt_pkg::KIND_WORD;
					app_base = '0;
				end else begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{char_s1, 1'b0,
						cwt_pkg::KIND_SYM, 1'b0};
					grp.n = grp.n + 1'b1;
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
						cwt_pkg::KIND_SYM, 1'b0};
					grp.n = grp.n + 1'b1;
				end
			end

			if (do_app) begin
				grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{app_ch, 1'b0, app_kind, 1'b0};
				grp.n   = grp.n + 1'b1;
				app_len = app_base + 1'b1;
				tlen_d  = app_len;
				if (app_len >= lim) begin
					grp.items[grp.n[cwt_pkg::IDX_W-1:0]] = '{cwt_pkg::CH_NUL, 1'b1,
						app_kind, 1'b0};
					grp.n  = grp.n + 1'b1;
					mode_d = cwt_pkg::MODE_IDLE;
					tlen_d = '0;
				end
			end
		end
	end

	`ASSERT_NEVER(a_err_needs_eoi, clk, arst_n, grp_load && grp.items[0].comment_error && !eoi_s1, "comment error without end of input")
	`ASSERT_NEVER(a_grp_count, clk, arst_n, valid_s1 && (grp.n > cwt_pkg::CNT_W'(cwt_pkg::ITEMS_MAX)), "result group over capacity")

endmodule

@@ rtl/cwt_outq.sv @@
`include "assert_macros.svh"

module cwt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  cwt_pkg::grp_t       grp,
	input  logic                grp_load,
	output logic                free,
	cwt_out_if.source           res
);

	cwt_pkg::res_t [cwt_pkg::ITEMS_MAX-1:0] items_q;
	logic [cwt_pkg::CNT_W-1:0]              rem_q;
	logic [cwt_pkg::IDX_W-1:0]              idx_q;
	logic                                   take;

	assign res.valid         = rem_q != '0;
	assign take              = res.valid && res.ready;
	assign free              = (rem_q == '0) || (rem_q == cwt_pkg::CNT_W'(1) && res.ready);
	assign res.token_char    = items_q[idx_q].token_char;
	assign res.token_end     = items_q[idx_q].token_end;
	assign res.token_kind    = items_q[idx_q].token_kind;
	assign res.comment_error = items_q[idx_q].comment_error;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (grp_load) begin
			rem_q <= grp.n;
			idx_q <= '0;
		end else if (take) begin
			rem_q <= rem_q - 1'b1;
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			items_q <= grp.items;
		end
	end

	`ASSERT_NEVER(a_load_busy, clk, arst_n, grp_load && !free, "group loaded over undelivered results")
	`ASSERT_NEVER(a_rem_range, clk, arst_n, rem_q > cwt_pkg::CNT_W'(cwt_pkg::ITEMS_MAX), "remaining count out of range")
	`ASSERT_CLK(a_drain_last, clk, arst_n, (take && rem_q == cwt_pkg::CNT_W'(1) && !grp_load) |=> !res.valid, "valid held after last result")

endmodule

@@ rtl/c_word_tokenizer_core.sv @@
// C source tokenizer: one source byte per input transaction, tokens out as a
// stream of characters each closed by an end item (token_end). Comments and
// white space are dropped; an unclosed block comment at end of input yields a
// single item with comment_error set. The byte passes an input register, is
// scanned combinationally against the scan state, and the zero to four result
// items it causes are loaded together into a result group that drains one
// item per cycle while the output is ready. A new byte is taken every cycle
// while the output is ready and each byte causes at most one result; a byte
// with more results stalls the next byte until its group has drained.
// max_token_length is written through the always ready configuration channel;
// the user must do so only while no transaction is in flight; not enforced.
module c_word_tokenizer_core (
	input  logic      clk,
	input  logic      arst_n,
	cwt_in_if.sink    src,
	cwt_cfg_if.sink   cfg,
	cwt_out_if.source res
);

	cwt_pkg::grp_t grp;
	logic          grp_load;
	logic          free;

	cwt_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.cfg      (cfg),
		.free     (free),
		.grp      (grp),
		.grp_load (grp_load)
	);

	cwt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.grp      (grp),
		.grp_load (grp_load),
		.free     (free),
		.res      (res)
	);

endmodule
